// File: rtl/mrm_pkg.sv
`default_nettype none

package mrm_pkg;

   localparam int WINDOW      = 5;
   localparam int CHANNELS    = 5;
   localparam int SAMPLE_BITS = 16;

   // Port widths are fixed by the item format.
   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 16;

   // Stored sample width: only the low SAMPLE_BITS bits of a sample are kept.
   localparam int SMP_W    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int PTR_W    = $clog2(WINDOW);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MID      = WINDOW / 2;

   typedef logic [SMP_W-1:0]    smp_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [CH_W-1:0]     channel_type;
   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [CH_IDX_W-1:0] ch_idx_type;
   typedef smp_type [WINDOW-1:0] win_type;

   typedef struct packed {
      logic        in_range;
      ch_idx_type  row;
      channel_type channel;
      smp_type     sample;
   } cmd_type;

   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } link_type;

   typedef struct packed {
      channel_type channel_out;
      sample_type  median;
   } rsp_type;

   // Drop the first copy of gone from a sorted window, insert fresh after all
   // entries equal to it. If gone is absent, the last entry is dropped.
   function automatic win_type replace_sorted(win_type win, smp_type gone, smp_type fresh);
      win_type           rest;
      win_type           rest_sh;
      win_type           res;
      logic [WINDOW-1:0] del;
      logic [WINDOW-1:0] le;
      logic [WINDOW-1:0] le_sh;
      logic              seen;
      seen = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
         seen   = seen | (win[i] == gone);
         del[i] = seen;
      end
      rest = '0;
      le   = '0;
      for (int j = 0; j < WINDOW - 1; j++) begin
         rest[j] = del[j] ? win[j+1] : win[j];
         le[j]   = (rest[j] <= fresh);
      end
      rest_sh = '0;
      le_sh   = '0;
      le_sh[0] = 1'b1;
      for (int k = 1; k < WINDOW; k++) begin
         rest_sh[k] = rest[k-1];
         le_sh[k]   = le[k-1];
      end
      for (int k = 0; k < WINDOW; k++) begin
         if (le[k]) begin
            res[k] = rest[k];
         end else if (le_sh[k]) begin
            res[k] = fresh;
         end else begin
            res[k] = rest_sh[k];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mrm_front.sv
`default_nettype none

module mrm_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire mrm_pkg::channel_type req_channel,
   input  wire mrm_pkg::sample_type  req_sample,
   input  wire logic                 take,
   output mrm_pkg::link_type         link
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   mrm_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   mrm_pkg::cmd_type cmd;
   logic             accept;
   logic             drain;

   // Classify: out-of-range channels pass through without touching state.
   always_comb begin
      cmd.in_range = (req_channel < mrm_pkg::CH_W'(mrm_pkg::CHANNELS))
                     || (mrm_pkg::CHANNELS > (1 << mrm_pkg::CH_W) - 1);
      cmd.row      = mrm_pkg::ch_idx_type'(req_channel);
      cmd.channel  = req_channel;
      cmd.sample   = mrm_pkg::smp_type'(req_sample);
   end

   assign full   = (count_ff == FULL_COUNT);
   assign accept = push && !full;
   assign drain  = take && (count_ff != 2'd0);

   assign link.avail = (count_ff != 2'd0);
   assign link.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = drain ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, drain};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mrm_back.sv
`default_nettype none

module mrm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mrm_pkg::link_type link,
   output logic                   take,
   output logic                   empty,
   input  wire logic              pop,
   output mrm_pkg::rsp_type       rsp
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   mrm_pkg::win_type  hist_ff [mrm_pkg::CHANNELS];
   mrm_pkg::win_type  sort_ff [mrm_pkg::CHANNELS];
   mrm_pkg::ptr_type  optr_ff [mrm_pkg::CHANNELS];

   mrm_pkg::rsp_type  rq_ff [2];
   logic              rwr_ptr_ff, rwr_ptr_in;
   logic              rrd_ptr_ff, rrd_ptr_in;
   logic [1:0]        rcount_ff, rcount_in;

   mrm_pkg::cmd_type  cmd;
   mrm_pkg::ptr_type  ptr;
   mrm_pkg::smp_type  gone;
   mrm_pkg::win_type  hist_row_in;
   mrm_pkg::win_type  sort_row_in;
   mrm_pkg::ptr_type  optr_row_in;
   mrm_pkg::rsp_type  result;
   logic              space;
   logic              deliver;
   logic              update;

   assign cmd     = link.cmd;
   assign deliver = pop && !empty;
   assign space   = (rcount_ff != FULL_COUNT) || deliver;
   assign take    = link.avail && space;
   assign update  = take && cmd.in_range;

   always_comb begin
      ptr         = optr_ff[cmd.row];
      gone        = hist_ff[cmd.row][ptr];
      hist_row_in = hist_ff[cmd.row];
      hist_row_in[ptr] = cmd.sample;
      optr_row_in = (ptr == mrm_pkg::ptr_type'(mrm_pkg::WINDOW - 1)) ? '0 : ptr + 1'b1;
      sort_row_in = mrm_pkg::replace_sorted(sort_ff[cmd.row], gone, cmd.sample);
      result.channel_out = cmd.channel;
      result.median      = cmd.in_range ?
                           mrm_pkg::sample_type'(sort_row_in[mrm_pkg::MID]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < mrm_pkg::CHANNELS; c++) begin
            hist_ff[c] <= '0;
            sort_ff[c] <= '0;
            optr_ff[c] <= '0;
         end
      end else if (update) begin
         hist_ff[cmd.row] <= hist_row_in;
         sort_ff[cmd.row] <= sort_row_in;
         optr_ff[cmd.row] <= optr_row_in;
      end
   end

   // Result queue: holds finished items until popped.
   assign empty = (rcount_ff == 2'd0);
   assign rsp   = rq_ff[rrd_ptr_ff];

   always_comb begin
      rwr_ptr_in = take ? ~rwr_ptr_ff : rwr_ptr_ff;
      rrd_ptr_in = deliver ? ~rrd_ptr_ff : rrd_ptr_ff;
      rcount_in  = rcount_ff + {1'b0, take} - {1'b0, deliver};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ptr_ff <= 1'b0;
         rrd_ptr_ff <= 1'b0;
         rcount_ff  <= 2'd0;
      end else begin
         rwr_ptr_ff <= rwr_ptr_in;
         rrd_ptr_ff <= rrd_ptr_in;
         rcount_ff  <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rq_ff[rwr_ptr_ff] <= result;
      end
   end

endmodule

`default_nettype wire

// File: rtl/multichannel_running_median_top.sv
// Channel   Direction  Handshake             Payload
// request   in         push / full           req_channel, req_sample
// response  out        empty / pop           rsp_channel_out, rsp_median
//
// One item per cycle sustained while neither side stalls; an item reaches the
// result ports via the command queue, then the sorted update and result queue.
// The sorted delete/insert over one channel's window sets the cycle time.
// Synchronous reset clears all windows and oldest pointers to zero.
// Either side may stall; each two-entry queue absorbs the slack.
`default_nettype none

module multichannel_running_median_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire mrm_pkg::channel_type req_channel,
   input  wire mrm_pkg::sample_type  req_sample,
   output logic                      empty,
   input  wire logic                 pop,
   output mrm_pkg::channel_type      rsp_channel_out,
   output mrm_pkg::sample_type       rsp_median
);

   mrm_pkg::link_type link;
   mrm_pkg::rsp_type  rsp;
   logic              take;

   mrm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .take        (take),
      .link        (link)
   );

   mrm_back u_back (
      .clock (clock),
      .reset (reset),
      .link  (link),
      .take  (take),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_channel_out = rsp.channel_out;
   assign rsp_median      = rsp.median;

`ifndef SYNTHESIS
   // An accepted item is waiting for the back end on the next cycle.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> link.avail)
      else $error("accepted item missing from command queue");

   // An item taken by the back end is waiting as a result on the next cycle.
   a_back_delivers: assert property (@(posedge clock) disable iff (reset)
      take |=> !empty)
      else $error("taken item missing from result queue");

   // An out-of-range item taken into an empty result queue reports a zero median.
   a_bad_channel_zero: assert property (@(posedge clock) disable iff (reset)
      take && !link.cmd.in_range |=> (rsp_median == '0) || !$past(empty))
      else $error("out-of-range channel reported nonzero median");
`endif

endmodule

`default_nettype wire
